// ===== hdl/range_bearing_frame_parser_defines.svh =====
// Assertion macros used by the range/bearing frame parser RTL.
`ifndef RANGE_BEARING_FRAME_PARSER_DEFINES_SVH
`define RANGE_BEARING_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define RBFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RBFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RBFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBFP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/rbfp_pkg.sv =====
// Types and constants of the range/bearing frame parser.
package rbfp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SLOT_W     = 2;
    localparam int unsigned ANGLE_W    = 15;
    localparam int unsigned DIST_W     = 8;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned RESULT_W   = SLOT_W + ANGLE_W + DIST_W;

    localparam int unsigned NUM_SLOTS = 3;

    localparam logic [BYTE_W-1:0] BYTE_START      = 8'd250;
    localparam logic [BYTE_W-1:0] BYTE_CLOSE      = 8'd255;
    localparam logic [6:0]        HUNDREDS_WEIGHT = 7'd100;

    typedef enum logic [2:0] {
        PS_IDLE     = 3'd0,
        PS_HUNDREDS = 3'd1,
        PS_UNITS    = 3'd2,
        PS_DIST     = 3'd3,
        PS_CLOSE    = 3'd4,
        PS_RESYNC   = 3'd5
    } parse_state_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [ANGLE_W-1:0] angle;
        logic [SLOT_W-1:0]  slot;
    } result_t;

    // Handshake between the parser and the result register.
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_xfer_t;

endpackage

// ===== hdl/rbfp_parser.sv =====
// Input byte register and frame state machine of the range/bearing frame parser.
`include "range_bearing_frame_parser_defines.svh"

module rbfp_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rbfp_pkg::BYTE_W-1:0]         in_byte,
    output rbfp_pkg::result_xfer_t              result,
    input  logic                                result_ready
);

    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic [rbfp_pkg::BYTE_W-1:0]        byte_reg;
    rbfp_pkg::parse_state_t             state_reg;
    rbfp_pkg::parse_state_t             state_next;
    logic [rbfp_pkg::BYTE_W-1:0]        hundreds_reg;
    logic [rbfp_pkg::ANGLE_W-1:0]       angle_reg;
    logic [rbfp_pkg::ANGLE_W-1:0]       angle_next;
    logic [rbfp_pkg::DIST_W-1:0]        distance_reg;
    logic [rbfp_pkg::SLOT_W-1:0]        slot_reg;
    logic [rbfp_pkg::SLOT_W-1:0]        slot_next;
    logic [4:0]                         slot_inc;
    logic                               consume;
    logic                               emit;
    logic                               load_hundreds;
    logic                               load_angle;
    logic                               load_distance;
    logic                               slot_clear;
    logic                               slot_advance;
    logic                               is_close;
    logic                               is_start;

    // Advance the held byte only when the result register can take a result, emitted or not.
    assign consume   = in_valid_reg && result_ready;
    assign in_ready  = !in_valid_reg || consume;
    assign is_close  = (byte_reg == rbfp_pkg::BYTE_CLOSE);
    assign is_start  = (byte_reg == rbfp_pkg::BYTE_START);

    always_comb
    begin
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (consume)
        begin
            case (state_reg)
                rbfp_pkg::PS_HUNDREDS: state_next = rbfp_pkg::PS_UNITS;
                rbfp_pkg::PS_UNITS:    state_next = rbfp_pkg::PS_DIST;
                rbfp_pkg::PS_DIST:     state_next = rbfp_pkg::PS_CLOSE;
                rbfp_pkg::PS_CLOSE:
                begin
                    if (is_close)
                    begin
                        state_next = rbfp_pkg::PS_IDLE;
                    end
                end
                rbfp_pkg::PS_RESYNC:
                begin
                    if (is_close)
                    begin
                        state_next = rbfp_pkg::PS_IDLE;
                    end
                end
                default:
                begin
                    if (is_start)
                    begin
                        state_next = rbfp_pkg::PS_HUNDREDS;
                    end
                    else if (is_close)
                    begin
                        state_next = rbfp_pkg::PS_RESYNC;
                    end
                    else
                    begin
                        state_next = rbfp_pkg::PS_IDLE;
                    end
                end
            endcase
        end
    end

    // Outputs of the state machine
    always_comb
    begin
        emit          = 1'b0;
        load_hundreds = 1'b0;
        load_angle    = 1'b0;
        load_distance = 1'b0;
        slot_clear    = 1'b0;
        slot_advance  = 1'b0;
        if (consume)
        begin
            case (state_reg)
                rbfp_pkg::PS_HUNDREDS: load_hundreds = 1'b1;
                rbfp_pkg::PS_UNITS:    load_angle    = 1'b1;
                rbfp_pkg::PS_DIST:     load_distance = 1'b1;
                rbfp_pkg::PS_CLOSE:
                begin
                    emit         = is_close;
                    slot_advance = is_close;
                end
                rbfp_pkg::PS_RESYNC:   slot_clear    = is_close;
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign angle_next = rbfp_pkg::ANGLE_W'({7'd0, hundreds_reg}
                                           * {8'd0, rbfp_pkg::HUNDREDS_WEIGHT})
                      + rbfp_pkg::ANGLE_W'(byte_reg);

    // Wrap at the slot count, then keep the low bits of the output width.
    assign slot_inc = {3'd0, slot_reg} + 5'd1;

    always_comb
    begin
        if (slot_clear)
        begin
            slot_next = '0;
        end
        else if (slot_advance)
        begin
            if (slot_inc >= 5'(rbfp_pkg::NUM_SLOTS))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_inc[rbfp_pkg::SLOT_W-1:0];
            end
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbfp_pkg::PS_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hundreds)
        begin
            hundreds_reg <= byte_reg;
        end
        if (load_angle)
        begin
            angle_reg <= angle_next;
        end
        if (load_distance)
        begin
            distance_reg <= byte_reg;
        end
    end

    assign result.valid         = emit;
    assign result.data.slot     = slot_reg;
    assign result.data.angle    = angle_reg;
    assign result.data.distance = distance_reg;

    `RBFP_ASSERT(a_slot_in_range, clk, rst_n,
        ({3'd0, slot_reg} < 5'(rbfp_pkg::NUM_SLOTS)) || (rbfp_pkg::NUM_SLOTS > 4),
        "slot index left its range")
    `RBFP_ASSERT(a_resync_clears_slot, clk, rst_n,
        (consume && state_reg == rbfp_pkg::PS_RESYNC && is_close) |=>
        (state_reg == rbfp_pkg::PS_IDLE && slot_reg == '0),
        "resync close did not clear slot")
    `RBFP_ASSERT(a_emit_returns_idle, clk, rst_n,
        emit |=> (state_reg == rbfp_pkg::PS_IDLE),
        "frame close did not return to idle")
    `RBFP_ASSERT(a_stall_holds_byte, clk, rst_n,
        (in_valid_reg && !consume) |=>
        (in_valid_reg && $stable(byte_reg) && $stable(state_reg)),
        "stalled byte was lost or state moved")

endmodule

// ===== hdl/rbfp_out_stage.sv =====
// Result register of the range/bearing frame parser, driving the master stream.
module rbfp_out_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rbfp_pkg::result_xfer_t              result,
    output logic                                result_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rbfp_pkg::OUT_DATA_W-1:0]     out_data
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    rbfp_pkg::result_t      data_reg;
    logic                   load;

    // Free when empty or when the held transfer completes this cycle.
    assign result_ready = !out_valid_reg || out_ready;
    assign load         = result.valid && result_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(rbfp_pkg::OUT_DATA_W - rbfp_pkg::RESULT_W){1'b0}}, data_reg};

endmodule

// ===== hdl/range_bearing_frame_parser.sv =====
// Top level of the range/bearing frame parser.
//
//  Channel   Dir  Payload (tdata, lowest bit first)
//  s_axis    in   rx_byte[7:0]
//  m_axis    out  slot[1:0], angle[16:2], distance[24:17], zero[31:25]
//
// One byte per cycle while m_axis_tready stays high; a result is valid on m_axis after its
// closing byte transfers in and passes the input byte register, then the result register.
// The frame state machine and one 8x7 multiply sit between the two registers.
// rst_n clears the byte and result valid flags, the parse state and the slot.
// While m_axis stalls with a result held, one more byte waits in the input
// register and s_axis then drops tready.
module range_bearing_frame_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rbfp_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // rx_byte[7:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rbfp_pkg::OUT_DATA_W-1:0]     m_axis_tdata    // slot, angle, distance
);

    rbfp_pkg::result_xfer_t result;
    logic                   result_ready;

    rbfp_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_byte      (s_axis_tdata),
        .result       (result),
        .result_ready (result_ready)
    );

    rbfp_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .result_ready (result_ready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata)
    );

endmodule
